// ===== design/tpwls_pkg.sv =====
// Package for the text punctuation and word-length statistics block.
// Holds shared widths, codes, the controller state type and command/status structs.
// No dependencies.
`default_nettype none

package tpwls_pkg;

  localparam int MAX_SLOTS       = 8;
  localparam int DEF_PUNCT_SLOTS = 8;
  localparam int DEF_COUNT_BITS  = 16;

  localparam int BYTE_W   = 8;
  localparam int SLOT_W   = 3;
  localparam int NUM_W    = 4;
  localparam int FIELD_W  = 16;
  localparam int MEAN_W   = 24;
  localparam int FRAC_W   = 8;
  localparam int WIDE_W   = 33;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [BYTE_W-1:0] SPACE_CODE = 8'h20;

  localparam logic [CFG_IDX_W-1:0] CFG_PUNCT_CHARS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PUNCT_IN_USE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUNCT,
    ST_DIV,
    ST_STATS
  } ctrl_state_t;

  typedef struct packed {
    logic              byte_en;
    logic              end_en;
    logic              clear;
    logic              stats_sel;
    logic [SLOT_W-1:0] slot;
  } dp_cmd_t;

  typedef struct packed {
    logic [NUM_W-1:0] n_active;
    logic             div_done;
  } dp_stat_t;

  function automatic logic [FIELD_W-1:0] sat16(input logic [WIDE_W-1:0] v);
    return (v > WIDE_W'(17'h0FFFF)) ? {FIELD_W{1'b1}} : v[FIELD_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== design/tpwls_ifs.sv =====
// Channel interfaces for the input bytes and the result items.
// Depends on tpwls_pkg for field widths.
`default_nettype none

interface tpwls_in_if;
  import tpwls_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] text_byte;
  logic              end_of_text;

  modport source(output valid, output text_byte, output end_of_text, input ready);
  modport sink(input valid, input text_byte, input end_of_text, output ready);
endinterface

interface tpwls_out_if;
  import tpwls_pkg::*;
  logic               valid;
  logic               ready;
  logic [SLOT_W-1:0]  punct_slot;
  logic [FIELD_W-1:0] punct_hits;
  logic [FIELD_W-1:0] word_count;
  logic [FIELD_W-1:0] letter_total;
  logic [MEAN_W-1:0]  mean_len_q8;
  logic [FIELD_W-1:0] shortest_len;
  logic [FIELD_W-1:0] longest_len;
  logic               is_stats;
  logic               last;

  modport source(output valid, output punct_slot, output punct_hits, output word_count,
                 output letter_total, output mean_len_q8, output shortest_len,
                 output longest_len, output is_stats, output last, input ready);
  modport sink(input valid, input punct_slot, input punct_hits, input word_count,
               input letter_total, input mean_len_q8, input shortest_len,
               input longest_len, input is_stats, input last, output ready);
endinterface

`default_nettype wire

// ===== design/tpwls_div.sv =====
// Restoring radix-2 divider for the mean word length, one quotient bit per cycle.
// Depends on tpwls_pkg for widths.
`default_nettype none

module tpwls_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [tpwls_pkg::MEAN_W-1:0]  dividend,
  input  wire logic [tpwls_pkg::FIELD_W-1:0] divisor,
  output logic                               done,
  output logic [tpwls_pkg::MEAN_W-1:0]       quotient
);
  import tpwls_pkg::*;

  localparam int CNT_W = $clog2(MEAN_W);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [FIELD_W-1:0] div_r;
  logic [FIELD_W-1:0] rem_r, rem_nxt;
  logic [MEAN_W-1:0]  quo_r, quo_nxt;
  logic [FIELD_W:0]   rem_sh;
  logic [FIELD_W:0]   rem_sub;

  always_comb begin
    rem_sh  = {rem_r, quo_r[MEAN_W-1]};
    rem_sub = rem_sh - {1'b0, div_r};
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, div_r}) begin
        rem_nxt = rem_sub[FIELD_W-1:0];
        quo_nxt = {quo_r[MEAN_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[FIELD_W-1:0];
        quo_nxt = {quo_r[MEAN_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(MEAN_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      div_r <= divisor;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== design/tpwls_dp.sv =====
// Datapath: configuration registers, slot match, saturating counters, word tracking,
// result payload selection. Depends on tpwls_pkg and instantiates tpwls_div.
`default_nettype none

module tpwls_dp #(
  parameter int PUNCT_SLOTS = tpwls_pkg::DEF_PUNCT_SLOTS,
  parameter int COUNT_BITS  = tpwls_pkg::DEF_COUNT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [tpwls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpwls_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire logic [tpwls_pkg::BYTE_W-1:0]     in_byte,
  input  wire tpwls_pkg::dp_cmd_t               cmd,
  output tpwls_pkg::dp_stat_t                   stat,
  output logic [tpwls_pkg::SLOT_W-1:0]          punct_slot,
  output logic [tpwls_pkg::FIELD_W-1:0]         punct_hits,
  output logic [tpwls_pkg::FIELD_W-1:0]         word_count,
  output logic [tpwls_pkg::FIELD_W-1:0]         letter_total,
  output logic [tpwls_pkg::MEAN_W-1:0]          mean_len_q8,
  output logic [tpwls_pkg::FIELD_W-1:0]         shortest_len,
  output logic [tpwls_pkg::FIELD_W-1:0]         longest_len,
  output logic                                  is_stats,
  output logic                                  last
);
  import tpwls_pkg::*;

  localparam int IDX_W   = (PUNCT_SLOTS > 1) ? $clog2(PUNCT_SLOTS) : 1;
  localparam int CHARS_W = PUNCT_SLOTS * BYTE_W;

  logic [CHARS_W-1:0]    chars_r;
  logic [NUM_W-1:0]      in_use_r;
  logic [NUM_W-1:0]      n_active;
  logic [PUNCT_SLOTS-1:0] hit;
  logic                  found;
  logic [COUNT_BITS-1:0] slot_cnt_r [PUNCT_SLOTS];
  logic [COUNT_BITS-1:0] space_r, byte_r, cur_r, min_r, max_r;
  logic [COUNT_BITS-1:0] min_close, max_close;
  logic                  is_space;
  logic [WIDE_W-1:0]     words_wide, letters_wide;
  logic [FIELD_W-1:0]    words16, letters16;
  logic                  div_done;
  logic [MEAN_W-1:0]     quo;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chars_r  <= '0;
      in_use_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PUNCT_CHARS) begin
        chars_r <= cfg_wdata[CHARS_W-1:0];
      end
      if (cfg_index == CFG_PUNCT_IN_USE) begin
        in_use_r <= cfg_wdata[NUM_W-1:0];
      end
    end
  end

  assign n_active = (in_use_r > NUM_W'(PUNCT_SLOTS)) ? NUM_W'(PUNCT_SLOTS) : in_use_r;

  // The lowest active slot holding the byte takes the hit.
  always_comb begin
    hit   = '0;
    found = 1'b0;
    for (int k = 0; k < PUNCT_SLOTS; k++) begin
      if (!found && (NUM_W'(k) < n_active) && (chars_r[BYTE_W*k +: BYTE_W] == in_byte)) begin
        hit[k] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  assign is_space  = (in_byte == SPACE_CODE);
  assign min_close = ((min_r == '0) || (min_r > cur_r)) ? cur_r : min_r;
  assign max_close = ((max_r == '0) || (max_r < cur_r)) ? cur_r : max_r;

  for (genvar g = 0; g < PUNCT_SLOTS; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n || cmd.clear) begin
        slot_cnt_r[g] <= '0;
      end else if (cmd.byte_en && hit[g] && (slot_cnt_r[g] != '1)) begin
        slot_cnt_r[g] <= slot_cnt_r[g] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      space_r <= '0;
      byte_r  <= '0;
      cur_r   <= '0;
      min_r   <= '0;
      max_r   <= '0;
    end else if (cmd.byte_en) begin
      if (byte_r != '1) begin
        byte_r <= byte_r + 1'b1;
      end
      if (is_space) begin
        if (space_r != '1) begin
          space_r <= space_r + 1'b1;
        end
        min_r <= min_close;
        max_r <= max_close;
        cur_r <= '0;
      end else if (cur_r != '1) begin
        cur_r <= cur_r + 1'b1;
      end
    end else if (cmd.end_en) begin
      min_r <= min_close;
      max_r <= max_close;
      cur_r <= '0;
    end
  end

  assign words_wide   = WIDE_W'(space_r) + WIDE_W'(byte_r != '0);
  assign letters_wide = WIDE_W'(byte_r) - WIDE_W'(space_r);
  assign words16      = sat16(words_wide);
  assign letters16    = sat16(letters_wide);

  tpwls_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.end_en),
    .dividend ({letters16, {FRAC_W{1'b0}}}),
    .divisor  (words16),
    .done     (div_done),
    .quotient (quo)
  );

  assign stat.n_active = n_active;
  assign stat.div_done = div_done;

  always_comb begin
    punct_slot   = '0;
    punct_hits   = '0;
    word_count   = '0;
    letter_total = '0;
    mean_len_q8  = '0;
    shortest_len = '0;
    longest_len  = '0;
    is_stats     = 1'b0;
    last         = 1'b0;
    if (cmd.stats_sel) begin
      word_count   = words16;
      letter_total = letters16;
      mean_len_q8  = (words16 != '0) ? quo : '0;
      shortest_len = sat16(WIDE_W'(min_r));
      longest_len  = sat16(WIDE_W'(max_r));
      is_stats     = 1'b1;
      last         = 1'b1;
    end else begin
      punct_slot = cmd.slot;
      punct_hits = sat16(WIDE_W'(slot_cnt_r[cmd.slot[IDX_W-1:0]]));
    end
  end

endmodule

`default_nettype wire

// ===== design/tpwls_ctrl.sv =====
// Controller state machine: byte intake, result sequencing, clearing after the statistics result.
// Depends on tpwls_pkg for the state type and the command/status structs.
`default_nettype none

module tpwls_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  input  wire logic                 in_end,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  input  wire tpwls_pkg::dp_stat_t  stat,
  output tpwls_pkg::dp_cmd_t        cmd
);
  import tpwls_pkg::*;

  ctrl_state_t       state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    slot_nxt      = slot_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    cmd.byte_en   = 1'b0;
    cmd.end_en    = 1'b0;
    cmd.clear     = 1'b0;
    cmd.stats_sel = 1'b0;
    cmd.slot      = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_end) begin
            cmd.end_en = 1'b1;
            slot_nxt   = '0;
            state_nxt  = (stat.n_active != '0) ? ST_PUNCT : ST_DIV;
          end else begin
            cmd.byte_en = 1'b1;
          end
        end
      end
      ST_PUNCT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if ((NUM_W'(slot_r) + 1'b1) == stat.n_active) begin
            state_nxt = ST_DIV;
          end else begin
            slot_nxt = slot_r + 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_STATS;
        end
      end
      ST_STATS: begin
        out_valid     = 1'b1;
        cmd.stats_sel = 1'b1;
        if (out_ready) begin
          cmd.clear = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/text_punct_and_word_length_stats.sv =====
// Top level of the text punctuation and word-length statistics block.
// Depends on tpwls_pkg, tpwls_ifs, tpwls_ctrl, tpwls_dp and tpwls_div.
`default_nettype none

// Text bytes are taken one per cycle while the block is idle, each compared with all
// active punctuation slots at once. An end-marker item closes the text and starts a
// restoring divider for the mean word length; the block offers one result per active
// slot, then the statistics result once the divider is done. With a consumer that is
// always ready, the divider alone sets how long input stays closed after an end
// marker, since the at most eight slot results fit inside its run. No input is taken
// until the statistics result is delivered.
module text_punct_and_word_length_stats #(
  parameter int PUNCT_SLOTS = tpwls_pkg::DEF_PUNCT_SLOTS,
  parameter int COUNT_BITS  = tpwls_pkg::DEF_COUNT_BITS
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  tpwls_in_if.sink                              in_ch,
  tpwls_out_if.source                           out_ch,
  input  wire logic                             cfg_we,
  input  wire logic [tpwls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tpwls_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tpwls_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  logic     in_ready;
  logic     out_valid;

  tpwls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_end    (in_ch.end_of_text),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  tpwls_dp #(
    .PUNCT_SLOTS (PUNCT_SLOTS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_byte      (in_ch.text_byte),
    .cmd          (cmd),
    .stat         (stat),
    .punct_slot   (out_ch.punct_slot),
    .punct_hits   (out_ch.punct_hits),
    .word_count   (out_ch.word_count),
    .letter_total (out_ch.letter_total),
    .mean_len_q8  (out_ch.mean_len_q8),
    .shortest_len (out_ch.shortest_len),
    .longest_len  (out_ch.longest_len),
    .is_stats     (out_ch.is_stats),
    .last         (out_ch.last)
  );

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("Input and result channels active together.");

  a_end_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ready && in_ch.end_of_text) |=> !in_ready)
    else $error("Input taken right after an end marker.");

  a_stats_reopens: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ch.ready && out_ch.is_stats) |=> in_ready)
    else $error("Input not reopened after the statistics item.");

  a_slot_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ch.is_stats) |-> (NUM_W'(out_ch.punct_slot) < stat.n_active))
    else $error("Punctuation item for an inactive slot.");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Testbench for the text punctuation and word-length statistics block.
// Checks every result against a built-in predictor under random stalls on both sides.
// Depends on tpwls_pkg, the channel interfaces in tpwls_ifs and the block's top level.

module tb;
  import tpwls_pkg::*;

  typedef struct {
    logic [SLOT_W-1:0]  slot;
    logic [FIELD_W-1:0] hits;
    logic [FIELD_W-1:0] words;
    logic [FIELD_W-1:0] letters;
    logic [MEAN_W-1:0]  mean;
    logic [FIELD_W-1:0] shortest;
    logic [FIELD_W-1:0] longest;
    logic               is_stats;
    logic               last;
  } text_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tpwls_in_if  in_ch();
  tpwls_out_if out_ch();

  text_punct_and_word_length_stats u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  logic [CFG_DATA_W-1:0] punct_set;
  logic [NUM_W-1:0]      slots_in_use;
  logic [FIELD_W-1:0]    slot_hits [MAX_SLOTS];
  logic [FIELD_W-1:0]    space_count;
  logic [FIELD_W-1:0]    byte_count;
  logic [FIELD_W-1:0]    word_len;
  logic [FIELD_W-1:0]    shortest_word;
  logic [FIELD_W-1:0]    longest_word;
  text_result_t          expected_results [$];
  int                    mismatch_count;
  bit                    in_no_gap;
  bit                    out_no_stall;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [FIELD_W-1:0] bump(input logic [FIELD_W-1:0] v);
    return (v == {FIELD_W{1'b1}}) ? v : v + 1'b1;
  endfunction

  function automatic void clear_text();
    for (int k = 0; k < MAX_SLOTS; k++) slot_hits[k] = '0;
    space_count   = '0;
    byte_count    = '0;
    word_len      = '0;
    shortest_word = '0;
    longest_word  = '0;
  endfunction

  function automatic void close_word();
    if (shortest_word == 0 || shortest_word > word_len) shortest_word = word_len;
    if (longest_word == 0 || longest_word < word_len) longest_word = word_len;
    word_len = '0;
  endfunction

  function automatic void predict_text_item(input logic [BYTE_W-1:0] b, input logic eot);
    int           n;
    bit           hit;
    logic [16:0]  words;
    logic [15:0]  letters;
    logic [31:0]  mean;
    text_result_t r;
    n = (slots_in_use > NUM_W'(MAX_SLOTS)) ? MAX_SLOTS : int'(slots_in_use);
    if (!eot) begin
      hit = 1'b0;
      for (int k = 0; k < n; k++) begin
        if (!hit && punct_set[8*k +: 8] == b) begin
          slot_hits[k] = bump(slot_hits[k]);
          hit = 1'b1;
        end
      end
      byte_count = bump(byte_count);
      if (b == SPACE_CODE) begin
        space_count = bump(space_count);
        close_word();
      end else begin
        word_len = bump(word_len);
      end
    end else begin
      close_word();
      r = '{default: '0};
      for (int k = 0; k < n; k++) begin
        r.slot = SLOT_W'(k);
        r.hits = slot_hits[k];
        expected_results = {expected_results, r};
      end
      words = {1'b0, space_count} + 17'(byte_count != 0);
      if (words > 17'h0FFFF) words = 17'h0FFFF;
      letters = byte_count - space_count;
      mean = (words != 0) ? ({16'd0, letters} << 8) / {15'd0, words} : 32'd0;
      r = '{default: '0};
      r.words    = words[15:0];
      r.letters  = letters;
      r.mean     = mean[MEAN_W-1:0];
      r.shortest = shortest_word;
      r.longest  = longest_word;
      r.is_stats = 1'b1;
      r.last     = 1'b1;
      expected_results = {expected_results, r};
      clear_text();
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    text_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item arrived with none pending");
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("punct_slot", 32'(want.slot), 32'(out_ch.punct_slot));
        check_field("punct_hits", 32'(want.hits), 32'(out_ch.punct_hits));
        check_field("word_count", 32'(want.words), 32'(out_ch.word_count));
        check_field("letter_total", 32'(want.letters), 32'(out_ch.letter_total));
        check_field("mean_len_q8", 32'(want.mean), 32'(out_ch.mean_len_q8));
        check_field("shortest_len", 32'(want.shortest), 32'(out_ch.shortest_len));
        check_field("longest_len", 32'(want.longest), 32'(out_ch.longest_len));
        check_field("is_stats", 32'(want.is_stats), 32'(out_ch.is_stats));
        check_field("last", 32'(want.last), 32'(out_ch.last));
      end
    end
  end

  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = out_no_stall ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
      @(negedge clk);
    end
  end

  task automatic send_item(input logic [BYTE_W-1:0] b, input logic eot);
    int gap;
    gap = in_no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.text_byte   <= b;
    in_ch.end_of_text <= eot;
    do @(posedge clk); while (!in_ch.ready);
    predict_text_item(b, eot);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic [BYTE_W-1:0] marker_byte);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
    send_item(marker_byte, 1'b1);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (30) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_PUNCT_CHARS) punct_set = data;
    else slots_in_use = data[NUM_W-1:0];
    @(negedge clk);
  endtask

  task automatic set_punctuation(input logic [CFG_DATA_W-1:0] chars,
                                 input logic [NUM_W-1:0] count);
    wait_idle();
    write_reg(CFG_PUNCT_CHARS, chars);
    write_reg(CFG_PUNCT_IN_USE, {{(CFG_DATA_W-NUM_W){1'b0}}, count});
  endtask

  function automatic logic [BYTE_W-1:0] random_text_byte();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return BYTE_W'(8'h61 + $urandom_range(0, 5));
    if (pick < 60) return SPACE_CODE;
    if (pick < 85) return punct_set[8*$urandom_range(0, 7) +: 8];
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  task automatic test_empty_text();
    send_item(8'h00, 1'b1);
    set_punctuation({CFG_DATA_W{1'b1}}, 4'd8);
    send_item(8'hFF, 1'b1);
  endtask

  task automatic test_punct_and_words();
    set_punctuation({8'h3F, 8'h21, 8'h3B, 8'h2E, 8'h3A, 8'h2D, 8'h2C, 8'h2E}, 4'd8);
    send_text(" Hi,  a.b! ?;-", 8'h2E);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h3F, 1'b0);
    send_item(SPACE_CODE, 1'b0);
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_too_many_slots();
    set_punctuation({8'h7E, 8'h2F, 8'h3F, 8'h21, 8'h3B, 8'h3A, 8'h2D, 8'h2C}, 4'hF);
    send_text("x-y ~/,", SPACE_CODE);
  endtask

  task automatic test_random_texts();
    string                 palette;
    int                    sent;
    int                    len;
    logic [CFG_DATA_W-1:0] chars;
    logic [NUM_W-1:0]      count;
    palette = ",.!?;:";
    sent = 0;
    while (sent < 325) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: chars = {$urandom, $urandom};
          1: chars = '0;
          2: chars = '1;
          default: begin
            for (int k = 0; k < MAX_SLOTS; k++) chars[8*k +: 8] = palette[$urandom_range(0, 5)];
          end
        endcase
        count = ($urandom_range(0, 3) == 0) ? NUM_W'($urandom_range(9, 15))
                                            : NUM_W'($urandom_range(0, 8));
        set_punctuation(chars, count);
      end
      in_no_gap    = ($urandom_range(0, 4) == 0);
      out_no_stall = ($urandom_range(0, 4) == 0);
      len = $urandom_range(0, 16);
      repeat (len) send_item(random_text_byte(), 1'b0);
      send_item(BYTE_W'($urandom_range(0, 255)), 1'b1);
      sent += len + 1;
    end
    in_no_gap    = 1'b0;
    out_no_stall = 1'b0;
  endtask

  initial begin
    rst_n             = 1'b0;
    in_ch.valid       = 1'b0;
    in_ch.text_byte   = '0;
    in_ch.end_of_text = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_wdata         = '0;
    punct_set         = '0;
    slots_in_use      = '0;
    mismatch_count    = 0;
    in_no_gap         = 1'b0;
    out_no_stall      = 1'b0;
    clear_text();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_text();
    test_punct_and_words();
    test_too_many_slots();
    test_random_texts();

    wait_idle();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
